>>> design/abp_pkg.sv
// Package: payload types, register indexes and reset values for the alpha blend pixel packer.
package abp_pkg;

  // Input item of one pixel transfer
  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic [7:0]         src_red;
    logic [7:0]         src_green;
    logic [7:0]         src_blue;
    logic [7:0]         src_alpha;
    logic [31:0]        dest_word;
  } in_t;

  // Result item: framebuffer write
  typedef struct packed {
    logic [31:0] write_address;
    logic [31:0] write_word;
  } out_t;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SIZES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RED_SHIFT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_SHIFT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_SHIFT    = 3'd7;

  // Register reset values
  localparam logic [31:0] FRAME_BASE_RST    = 32'd0;
  localparam logic [13:0] SCREEN_WIDTH_RST  = 14'd0;
  localparam logic [13:0] SCREEN_HEIGHT_RST = 14'd0;
  localparam logic [15:0] ROW_PITCH_RST     = 16'd0;
  localparam logic [11:0] CHANNEL_SIZES_RST = 12'h888;
  localparam logic [4:0]  RED_SHIFT_RST     = 5'd16;
  localparam logic [4:0]  GREEN_SHIFT_RST   = 5'd8;
  localparam logic [4:0]  BLUE_SHIFT_RST    = 5'd0;

  // Blend constants
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
  localparam logic [15:0] BLEND_ROUND  = 16'd128;
  localparam logic [3:0]  SIZE_MAX     = 4'd8;

endpackage

>>> design/alpha_blend_pixel_pack_top.sv
// Top level: three-stage pipelined source-over alpha blend and pixel pack.
//
// One pixel is taken every clock (busy stays low) and its write, if any, shows
// on out_data with out_valid high for one cycle once the pixel has passed the
// three register stages: coordinate check, row multiply and channel blend
// products; address sum, channel select and size scaling product; divide by
// 255 and field packing. Pixels off the screen or with zero alpha leave the
// pipeline without a result. The receiver cannot stall, so results are never
// held back. Registers may be written only while no pixel is in flight.
module alpha_blend_pixel_pack_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  abp_pkg::in_t                        in_data,
  output logic                                out_valid,
  output abp_pkg::out_t                       out_data,
  input  logic                                cfg_we,
  input  logic [abp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [abp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers
  logic [31:0] frame_base_r;
  logic [13:0] screen_width_r;
  logic [13:0] screen_height_r;
  logic [15:0] row_pitch_r;
  logic [11:0] channel_sizes_r;
  logic [4:0]  red_shift_r;
  logic [4:0]  green_shift_r;
  logic [4:0]  blue_shift_r;

  // Capture register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r    <= abp_pkg::FRAME_BASE_RST;
      screen_width_r  <= abp_pkg::SCREEN_WIDTH_RST;
      screen_height_r <= abp_pkg::SCREEN_HEIGHT_RST;
      row_pitch_r     <= abp_pkg::ROW_PITCH_RST;
      channel_sizes_r <= abp_pkg::CHANNEL_SIZES_RST;
      red_shift_r     <= abp_pkg::RED_SHIFT_RST;
      green_shift_r   <= abp_pkg::GREEN_SHIFT_RST;
      blue_shift_r    <= abp_pkg::BLUE_SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        abp_pkg::REG_FRAME_BASE:    frame_base_r    <= cfg_data;
        abp_pkg::REG_SCREEN_WIDTH:  screen_width_r  <= cfg_data[13:0];
        abp_pkg::REG_SCREEN_HEIGHT: screen_height_r <= cfg_data[13:0];
        abp_pkg::REG_ROW_PITCH:     row_pitch_r     <= cfg_data[15:0];
        abp_pkg::REG_CHANNEL_SIZES: channel_sizes_r <= cfg_data[11:0];
        abp_pkg::REG_RED_SHIFT:     red_shift_r     <= cfg_data[4:0];
        abp_pkg::REG_GREEN_SHIFT:   green_shift_r   <= cfg_data[4:0];
        abp_pkg::REG_BLUE_SHIFT:    blue_shift_r    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // The pipeline never stalls
  assign busy = 1'b0;

  logic in_xfer;
  assign in_xfer = start && !busy;

  // ---------------- Stage 1: check, row multiply, blend products ----------
  logic        hit_nxt;
  logic [7:0]  inv_alpha;
  logic [15:0] mix_r_nxt, mix_g_nxt, mix_b_nxt;
  logic [30:0] row_off_nxt;
  logic [31:0] base_col_nxt;

  always_comb begin
    hit_nxt = !in_data.x_coord[15] && !in_data.y_coord[15]
              && (in_data.x_coord[13:0] < screen_width_r) && !in_data.x_coord[14]
              && (in_data.y_coord[13:0] < screen_height_r) && !in_data.y_coord[14]
              && (in_data.src_alpha != abp_pkg::ALPHA_CLEAR);
    inv_alpha = abp_pkg::ALPHA_OPAQUE - in_data.src_alpha;
    mix_r_nxt = 16'(in_data.src_red) * 16'(in_data.src_alpha)
                + 16'(in_data.dest_word[23:16]) * 16'(inv_alpha) + abp_pkg::BLEND_ROUND;
    mix_g_nxt = 16'(in_data.src_green) * 16'(in_data.src_alpha)
                + 16'(in_data.dest_word[15:8]) * 16'(inv_alpha) + abp_pkg::BLEND_ROUND;
    mix_b_nxt = 16'(in_data.src_blue) * 16'(in_data.src_alpha)
                + 16'(in_data.dest_word[7:0]) * 16'(inv_alpha) + abp_pkg::BLEND_ROUND;
    row_off_nxt = 31'(in_data.y_coord[14:0]) * 31'(row_pitch_r);
    base_col_nxt = frame_base_r + {15'd0, in_data.x_coord[14:0], 2'b00};
  end

  logic        v1_r;
  logic        opaque1_r;
  logic [7:0]  src_r1_r, src_g1_r, src_b1_r;
  logic [15:0] mix_r1_r, mix_g1_r, mix_b1_r;
  logic [30:0] row_off1_r;
  logic [31:0] base_col1_r;

  // Advance stage 1 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_xfer && hit_nxt;
    end
  end

  // Hold stage 1 payload
  always_ff @(posedge clk) begin
    opaque1_r   <= (in_data.src_alpha == abp_pkg::ALPHA_OPAQUE);
    src_r1_r    <= in_data.src_red;
    src_g1_r    <= in_data.src_green;
    src_b1_r    <= in_data.src_blue;
    mix_r1_r    <= mix_r_nxt;
    mix_g1_r    <= mix_g_nxt;
    mix_b1_r    <= mix_b_nxt;
    row_off1_r  <= row_off_nxt;
    base_col1_r <= base_col_nxt;
  end

  // ---------------- Stage 2: address sum, channel select, scale product ---
  logic [3:0]  size_r, size_g, size_b;
  logic [7:0]  scl_r, scl_g, scl_b;
  logic [7:0]  chan_r, chan_g, chan_b;
  logic [15:0] prod_r_nxt, prod_g_nxt, prod_b_nxt;
  logic [31:0] addr_nxt;

  always_comb begin
    // Clamp oversized channels to eight bits
    size_r = (channel_sizes_r[3:0]  > abp_pkg::SIZE_MAX) ? abp_pkg::SIZE_MAX
                                                          : channel_sizes_r[3:0];
    size_g = (channel_sizes_r[7:4]  > abp_pkg::SIZE_MAX) ? abp_pkg::SIZE_MAX
                                                          : channel_sizes_r[7:4];
    size_b = (channel_sizes_r[11:8] > abp_pkg::SIZE_MAX) ? abp_pkg::SIZE_MAX
                                                          : channel_sizes_r[11:8];
    scl_r = 8'((9'd1 << size_r) - 9'd1);
    scl_g = 8'((9'd1 << size_g) - 9'd1);
    scl_b = 8'((9'd1 << size_b) - 9'd1);
    chan_r = opaque1_r ? src_r1_r : mix_r1_r[15:8];
    chan_g = opaque1_r ? src_g1_r : mix_g1_r[15:8];
    chan_b = opaque1_r ? src_b1_r : mix_b1_r[15:8];
    prod_r_nxt = 16'(chan_r) * 16'(scl_r);
    prod_g_nxt = 16'(chan_g) * 16'(scl_g);
    prod_b_nxt = 16'(chan_b) * 16'(scl_b);
    addr_nxt = base_col1_r + {1'b0, row_off1_r};
  end

  logic        v2_r;
  logic [15:0] prod_r2_r, prod_g2_r, prod_b2_r;
  logic [31:0] addr2_r;

  // Advance stage 2 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  // Hold stage 2 payload
  always_ff @(posedge clk) begin
    prod_r2_r <= prod_r_nxt;
    prod_g2_r <= prod_g_nxt;
    prod_b2_r <= prod_b_nxt;
    addr2_r   <= addr_nxt;
  end

  // ---------------- Stage 3: divide by 255 and pack ------------------------
  // floor(p/255) = (p + (p >> 8) + 1) >> 8, exact for p up to 255*255, which covers every product here
  logic [16:0] quo_r_full, quo_g_full, quo_b_full;
  logic [7:0]  quo_r, quo_g, quo_b;
  logic [31:0] word_nxt;

  always_comb begin
    quo_r_full = 17'(prod_r2_r) + 17'(prod_r2_r[15:8]) + 17'd1;
    quo_g_full = 17'(prod_g2_r) + 17'(prod_g2_r[15:8]) + 17'd1;
    quo_b_full = 17'(prod_b2_r) + 17'(prod_b2_r[15:8]) + 17'd1;
    quo_r = quo_r_full[15:8];
    quo_g = quo_g_full[15:8];
    quo_b = quo_b_full[15:8];
    word_nxt = ({24'd0, quo_r} << red_shift_r)
             | ({24'd0, quo_g} << green_shift_r)
             | ({24'd0, quo_b} << blue_shift_r);
  end

  logic          out_valid_r;
  abp_pkg::out_t out_data_r;

  // Advance output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
    end
  end

  // Hold output payload
  always_ff @(posedge clk) begin
    out_data_r.write_address <= addr2_r;
    out_data_r.write_word    <= word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- Assertions ---------------------------------------------
  a_out_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(v2_r))
    else $error("result strobe without a stage 2 pixel");

  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(v1_r, 2))
    else $error("result strobe without a stage 1 pixel");

  a_clear_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_data.src_alpha == abp_pkg::ALPHA_CLEAR)) |-> ##3 !out_valid_r)
    else $error("transparent pixel produced a write");

  a_neg_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_data.x_coord[15] || in_data.y_coord[15])) |-> ##3 !out_valid_r)
    else $error("negative coordinate produced a write");

endmodule
